FILE: design/srfc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// srfc_pkg
// Shared types, constants and the CRC-16 byte update for the reply frame
// checker.
// ----------------------------------------------------------------------------
package srfc_pkg;

    // frame layout
    localparam int unsigned FRAME_LEN   = 8;
    localparam int unsigned CRC_BYTES   = 6;
    localparam int unsigned COUNT_W     = 4;
    localparam int unsigned IDX_W       = $clog2(FRAME_LEN);

    localparam logic [COUNT_W-1:0] COUNT_MAX   = 4'd15;
    localparam logic [COUNT_W-1:0] COUNT_FRAME = 4'd8;
    localparam logic [COUNT_W-1:0] COUNT_LAST  = 4'd7;
    localparam logic [COUNT_W-1:0] COUNT_CRC   = 4'd6;

    // crc-16/modbus
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // configuration register indexes
    typedef enum logic [0:0] {
        CFG_FUNC_CODE = 1'b0,
        CFG_DATA_LEN  = 1'b1
    } t_cfg_index;

    localparam logic [7:0] FUNC_CODE_RESET = 8'd3;
    localparam logic [7:0] DATA_LEN_RESET  = 8'd4;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_LENGTH  = 2'd1,
        ST_CRC     = 2'd2,
        ST_HEADER  = 2'd3
    } t_status;

    // one byte through the reflected crc, bit by bit
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
        logic [15:0] crc;
        crc = crc_in ^ {8'h00, data};
        for (int k = 0; k < 8; k++) begin
            if (crc[0]) begin
                crc = (crc >> 1) ^ CRC_POLY;
            end else begin
                crc = crc >> 1;
            end
        end
        return crc;
    endfunction

endpackage
`default_nettype wire

FILE: design/sensor_reply_frame_checker_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sensor_reply_frame_checker_core
// Checks the 8-byte reply of a humidity/temperature sensor: length, CRC-16
// and header, and keeps the last good humidity and temperature words.
// ----------------------------------------------------------------------------
// Usage
//   Input channel: one reply byte per beat on i_rx_byte, with i_frame_end
//   high on the last byte of a transfer. A beat is taken when i_in_valid is
//   high and o_in_stall is low.
//   Output channel: one result beat per transfer (status and the latched
//   readings), taken when o_out_valid is high and i_out_stall is low.
//   Config: i_cfg_we with i_cfg_index selects the expected function code
//   (index 0) or the expected data length (index 1); written while idle.
// Timing
//   A byte is held in the input register and is folded into the count,
//   frame store and CRC (one unrolled byte step) when it advances, and the
//   result register is loaded as the last byte advances. One byte per
//   cycle is sustained while no held result stalls a frame end.
// Reset and stalls
//   Reset clears the count, readings and both valid flags and sets the CRC
//   to FFFF; the config registers return to 3 and 4. While a result is held by the receiver,
//   bytes that do not end a frame keep flowing; a frame end waits in the
//   input register and o_in_stall is raised until the output is free.
// ----------------------------------------------------------------------------
module sensor_reply_frame_checker_core (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // config port
    input  wire logic                 i_cfg_we,
    input  wire srfc_pkg::t_cfg_index i_cfg_index,
    input  wire logic [7:0]           i_cfg_data,
    // input channel
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire logic [7:0]           i_rx_byte,
    input  wire logic                 i_frame_end,
    // output channel
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output logic [1:0]                o_status,
    output logic [15:0]               o_humidity_raw,
    output logic [15:0]               o_temperature_raw
);
    import srfc_pkg::*;

    // config registers
    logic [7:0] r_func_code;
    logic [7:0] r_data_len;

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_end;

    // frame state
    logic [COUNT_W-1:0] r_count;
    logic [15:0]        r_crc;
    logic [7:0]         r_frame [FRAME_LEN];
    logic [15:0]        r_hum;
    logic [15:0]        r_temp;

    // result register
    logic       r_out_valid;
    t_status    r_status;

    logic               out_free;
    logic               advance;
    logic               in_take;
    logic [COUNT_W-1:0] n_count;
    t_status            n_status;

    // handshake
    assign out_free   = !r_out_valid || !i_out_stall;
    assign advance    = r_in_valid && (!r_in_end || out_free);
    assign o_in_stall = r_in_valid && !advance;
    assign in_take    = i_in_valid && !o_in_stall;

    // saturating count including the current byte
    assign n_count = (r_count < COUNT_MAX) ? r_count + 4'd1 : r_count;

    // frame checks; a full frame ends with the current byte in slot seven
    always_comb begin
        if (n_count != COUNT_FRAME) begin
            n_status = ST_LENGTH;
        end else if (r_frame[COUNT_CRC[IDX_W-1:0]] != r_crc[7:0] ||
                     r_in_byte != r_crc[15:8]) begin
            n_status = ST_CRC;
        end else if (r_frame[0] != r_func_code || r_frame[1] != r_data_len) begin
            n_status = ST_HEADER;
        end else begin
            n_status = ST_OK;
        end
    end

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_func_code <= FUNC_CODE_RESET;
            r_data_len  <= DATA_LEN_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_FUNC_CODE: r_func_code <= i_cfg_data;
                CFG_DATA_LEN:  r_data_len  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte <= i_rx_byte;
            r_in_end  <= i_frame_end;
        end
    end

    // count and crc
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_crc   <= CRC_INIT;
        end else if (advance) begin
            if (r_in_end) begin
                r_count <= '0;
                r_crc   <= CRC_INIT;
            end else begin
                r_count <= n_count;
                if (r_count < COUNT_CRC) begin
                    r_crc <= crc_byte(r_crc, r_in_byte);
                end
            end
        end
    end

    // frame byte store, no reset
    always_ff @(posedge i_clk) begin
        if (advance && r_count < COUNT_FRAME) begin
            r_frame[r_count[IDX_W-1:0]] <= r_in_byte;
        end
    end

    // latched readings
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hum  <= '0;
            r_temp <= '0;
        end else if (advance && r_in_end && n_status == ST_OK) begin
            r_hum  <= {r_frame[2], r_frame[3]};
            r_temp <= {r_frame[4], r_frame[5]};
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_in_end) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_end) begin
            r_status <= n_status;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_status          = r_status;
    assign o_humidity_raw    = r_hum;
    assign o_temperature_raw = r_temp;

endmodule
`default_nettype wire

FILE: design/srfc_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// srfc_checker
// Port-level assertions for the reply frame checker, bound to the top level.
// ----------------------------------------------------------------------------
module srfc_checker (
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 o_in_stall,
    input wire logic                 o_out_valid,
    input wire logic                 i_out_stall,
    input wire logic [1:0]           o_status,
    input wire logic [15:0]          o_humidity_raw,
    input wire logic [15:0]          o_temperature_raw
);
    import srfc_pkg::*;

    // a held result beat keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_status) &&
        $stable(o_humidity_raw) && $stable(o_temperature_raw))
        else $error("result beat changed while stalled");

    // input back-pressure only comes from a held result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without a held result");

    // no result straight out of reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // readings move only with a fresh good result
    a_hum_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && !$stable(o_humidity_raw) |->
        o_out_valid && o_status == ST_OK)
        else $error("humidity changed without a good frame");

    a_temp_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && !$stable(o_temperature_raw) |->
        o_out_valid && o_status == ST_OK)
        else $error("temperature changed without a good frame");

endmodule

bind sensor_reply_frame_checker_core srfc_checker u_srfc_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_in_stall        (o_in_stall),
    .o_out_valid       (o_out_valid),
    .i_out_stall       (i_out_stall),
    .o_status          (o_status),
    .o_humidity_raw    (o_humidity_raw),
    .o_temperature_raw (o_temperature_raw)
);
`default_nettype wire

FILE: test/sensor_reply_frame_checker_core_tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sensor_reply_frame_checker_core_tb
// Self-checking bench for the sensor reply frame checker. A short table of
// directed frames runs first: reset readings, byte extremes, crc, header and
// length failures. Several configuration phases with random frames follow.
// Most of them are well-formed replies, and the rest are noise and broken
// frames. Every reply byte taken is folded into a local copy of the checker
// state, and each result beat is compared field by field with the oldest
// predicted reply. Both channels see random gaps and stalls.
// ----------------------------------------------------------------------------
module sensor_reply_frame_checker_core_tb;
    import srfc_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned PHASE_BYTES = 300;
    localparam int unsigned BUF_LEN     = 24;

    // how bytes 6 and 7 of a stimulus frame are formed
    typedef enum logic [1:0] {
        CRC_KEEP = 2'd0,
        CRC_FIX  = 2'd1,
        CRC_BAD  = 2'd2
    } t_crc_mode;

    typedef struct packed {
        t_status     status;
        logic [15:0] hum;
        logic [15:0] tmp;
    } t_reading;

    // one directed frame; byte 0 is the leftmost byte of the bytes field
    typedef struct packed {
        logic [4:0]       n;
        t_crc_mode        crc_mode;
        logic             typed;
        t_status          status;
        logic [15:0]      hum;
        logic [15:0]      tmp;
        logic [0:15][7:0] bytes;
    } t_dir_row;

    localparam int unsigned DIR_COUNT = 5;
    localparam t_dir_row DIR_ROWS [0:DIR_COUNT-1] = '{
        // single zero byte straight after reset
        '{5'd1, CRC_KEEP, 1'b1, ST_LENGTH, 16'h0000, 16'h0000, 128'h0},
        // good frame with byte extremes in the readings
        '{5'd8, CRC_FIX,  1'b1, ST_OK,     16'hFFFF, 16'h0000,
          128'h0304_FFFF_0000_0000_0000_0000_0000_0000},
        // corrupted crc keeps the readings
        '{5'd8, CRC_BAD,  1'b1, ST_CRC,    16'hFFFF, 16'h0000,
          128'h0304_1234_5678_0000_0000_0000_0000_0000},
        // wrong function code with a valid crc
        '{5'd8, CRC_FIX,  1'b1, ST_HEADER, 16'hFFFF, 16'h0000,
          128'hFF04_1234_5678_0000_0000_0000_0000_0000},
        // one byte too many
        '{5'd9, CRC_FIX,  1'b1, ST_LENGTH, 16'hFFFF, 16'h0000,
          128'h0304_1234_5678_0000_FF00_0000_0000_0000}
    };

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_cfg_we    = 1'b0;
    t_cfg_index        i_cfg_index = CFG_FUNC_CODE;
    logic [7:0]        i_cfg_data  = 8'h00;
    logic              i_in_valid  = 1'b0;
    logic              o_in_stall;
    logic [7:0]        i_rx_byte   = 8'h00;
    logic              i_frame_end = 1'b0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    logic [1:0]        o_status;
    logic [15:0]       o_humidity_raw;
    logic [15:0]       o_temperature_raw;

    // local copy of the checker state
    logic [3:0]        p_count;
    logic [15:0]       p_crc;
    logic [7:0]        p_bytes [0:7];
    logic [15:0]       p_hum;
    logic [15:0]       p_tmp;
    logic [7:0]        cfg_fc;
    logic [7:0]        cfg_len;

    t_reading          pending_replies [$];
    t_reading          want;
    t_reading          typed_reply;
    logic              typed_on = 1'b0;
    logic [7:0]        frame_buf [0:BUF_LEN-1];
    int unsigned       err_count = 0;
    int unsigned       reply_idx = 0;
    int unsigned       cycle_cnt = 0;
    int unsigned       stall_left = 0;
    int unsigned       stall_pick;

    sensor_reply_frame_checker_core u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_rx_byte         (i_rx_byte),
        .i_frame_end       (i_frame_end),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_status          (o_status),
        .o_humidity_raw    (o_humidity_raw),
        .o_temperature_raw (o_temperature_raw)
    );

    // clock
    always begin
        #5 i_clk = ~i_clk;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // reflected crc-16, one data bit at a time, lsb first
    function automatic logic [15:0] crc16_step(input logic [15:0] c, input logic [7:0] d);
        logic [15:0] acc;
        logic        fb;
        acc = c;
        for (int i = 0; i < 8; i++) begin
            fb  = acc[0] ^ d[i];
            acc = {1'b0, acc[15:1]};
            if (fb) begin
                acc = acc ^ CRC_POLY;
            end
        end
        return acc;
    endfunction

    // fold one accepted byte into the local state; a frame end gives a reply
    function automatic void fold_byte(input logic [7:0] b, input logic fe,
                                      output logic has, output t_reading r);
        if (p_count < COUNT_FRAME) begin
            p_bytes[p_count[2:0]] = b;
        end
        if (p_count < COUNT_CRC) begin
            p_crc = crc16_step(p_crc, b);
        end
        if (p_count != COUNT_MAX) begin
            p_count = p_count + 4'd1;
        end
        has = fe;
        r   = '0;
        if (fe) begin
            if (p_count != COUNT_FRAME) begin
                r.status = ST_LENGTH;
            end else if (p_bytes[6] != p_crc[7:0] || p_bytes[7] != p_crc[15:8]) begin
                r.status = ST_CRC;
            end else if (p_bytes[0] != cfg_fc || p_bytes[1] != cfg_len) begin
                r.status = ST_HEADER;
            end else begin
                r.status = ST_OK;
                p_hum    = {p_bytes[2], p_bytes[3]};
                p_tmp    = {p_bytes[4], p_bytes[5]};
            end
            r.hum   = p_hum;
            r.tmp   = p_tmp;
            p_count = '0;
            p_crc   = CRC_INIT;
        end
    endfunction

    task automatic flag_mismatch(input string msg);
        $display("mismatch at reply %0d: %s", reply_idx, msg);
        err_count++;
    endtask

    // short gaps mostly, now and then a long one
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 65) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // receiver stall pattern: free runs, short and long stalls
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_left  <= 0;
        end else if (stall_left == 0) begin
            stall_pick = $urandom_range(0, 99);
            if (stall_pick < 50) begin
                i_out_stall <= 1'b0;
                stall_left  <= $urandom_range(1, 25);
            end else if (stall_pick < 88) begin
                i_out_stall <= 1'b1;
                stall_left  <= $urandom_range(1, 3);
            end else begin
                i_out_stall <= 1'b1;
                stall_left  <= $urandom_range(10, 40);
            end
        end else begin
            stall_left <= stall_left - 1;
        end
    end

    // result beats against the oldest predicted reply
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_replies.size() == 0) begin
                flag_mismatch("result beat with no reply expected");
            end else begin
                want = pending_replies.pop_front();
                if (o_status !== want.status) begin
                    flag_mismatch($sformatf("status %0d, want %0d", o_status, want.status));
                end
                if (o_humidity_raw !== want.hum) begin
                    flag_mismatch($sformatf("humidity %h, want %h", o_humidity_raw, want.hum));
                end
                if (o_temperature_raw !== want.tmp) begin
                    flag_mismatch($sformatf("temperature %h, want %h",
                                            o_temperature_raw, want.tmp));
                end
            end
            reply_idx++;
        end
    end

    // one input beat; valid stays high into the next beat unless a gap follows
    task automatic send_beat(input logic [7:0] b, input logic fe, input bit gaps);
        logic        has;
        t_reading    pr;
        int unsigned g;
        i_in_valid  <= 1'b1;
        i_rx_byte   <= b;
        i_frame_end <= fe;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        fold_byte(b, fe, has, pr);
        if (has) begin
            pending_replies.push_back(typed_on ? typed_reply : pr);
        end
        g = gaps ? pick_gap() : 0;
        if (g != 0) begin
            i_in_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    task automatic send_frame(input int unsigned n, input bit gaps);
        for (int unsigned i = 0; i < n; i++) begin
            send_beat(frame_buf[i], i == n - 1, gaps);
        end
    endtask

    // crc bytes 6 and 7 over bytes 0 to 5, optionally broken
    task automatic apply_crc(input t_crc_mode mode);
        logic [15:0] c;
        if (mode != CRC_KEEP) begin
            c = CRC_INIT;
            for (int i = 0; i < 6; i++) begin
                c = crc16_step(c, frame_buf[i]);
            end
            frame_buf[6] = c[7:0];
            frame_buf[7] = c[15:8];
            if (mode == CRC_BAD) begin
                frame_buf[6] = frame_buf[6] ^ (8'h01 << $urandom_range(0, 7));
            end
        end
    endtask

    // hold the sender until every reply is back, then let the pipe settle
    task automatic wait_replies_done(input int unsigned settle);
        i_in_valid <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (pending_replies.size() != 0);
        repeat (settle) @(posedge i_clk);
    endtask

    // both registers back to back, only while idle
    task automatic write_cfg_pair(input logic [7:0] fc, input logic [7:0] len);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_FUNC_CODE;
        i_cfg_data  <= fc;
        @(posedge i_clk);
        i_cfg_index <= CFG_DATA_LEN;
        i_cfg_data  <= len;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cfg_fc  = fc;
        cfg_len = len;
    endtask

    // mostly well-formed replies, the rest noise and broken frames
    task automatic build_random_frame(output int unsigned n);
        int unsigned r;
        int unsigned sub;
        for (int i = 0; i < BUF_LEN; i++) begin
            frame_buf[i] = 8'($urandom_range(0, 255));
        end
        r   = $urandom_range(0, 99);
        sub = $urandom_range(0, 99);
        if (r < 72) begin
            n = 8;
            frame_buf[0] = cfg_fc;
            frame_buf[1] = cfg_len;
            if (sub < 8) begin
                frame_buf[0] = cfg_fc ^ 8'($urandom_range(1, 255));
            end else if (sub < 16) begin
                frame_buf[1] = cfg_len ^ 8'($urandom_range(1, 255));
            end
            apply_crc(sub < 94 ? CRC_FIX : CRC_BAD);
        end else if (r < 80) begin
            n = 8;
            apply_crc(CRC_FIX);
        end else if (r < 86) begin
            n = 8;
        end else begin
            if (sub < 50) begin
                n = $urandom_range(1, 7);
            end else if (sub < 80) begin
                n = $urandom_range(9, 15);
            end else begin
                n = $urandom_range(16, BUF_LEN);
            end
            frame_buf[0] = cfg_fc;
            frame_buf[1] = cfg_len;
            apply_crc(CRC_FIX);
        end
    endtask

    initial begin
        int unsigned n;
        int unsigned sent;
        logic [7:0]  fc;
        logic [7:0]  len;

        p_count = '0;
        p_crc   = CRC_INIT;
        p_hum   = '0;
        p_tmp   = '0;
        cfg_fc  = FUNC_CODE_RESET;
        cfg_len = DATA_LEN_RESET;
        for (int i = 0; i < 8; i++) begin
            p_bytes[i] = '0;
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed frames under the reset configuration
        for (int k = 0; k < DIR_COUNT; k++) begin
            for (int i = 0; i < BUF_LEN; i++) begin
                frame_buf[i] = (i < 16) ? DIR_ROWS[k].bytes[i] : 8'hA5;
            end
            apply_crc(DIR_ROWS[k].crc_mode);
            typed_on    = DIR_ROWS[k].typed;
            typed_reply = '{DIR_ROWS[k].status, DIR_ROWS[k].hum, DIR_ROWS[k].tmp};
            send_frame(DIR_ROWS[k].n, 1'b1);
        end
        typed_on = 1'b0;

        // random phases, configuration extremes among them
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin
                    fc  = 8'h00;
                    len = 8'h00;
                end
                1: begin
                    fc  = 8'hFF;
                    len = 8'hFF;
                end
                4: begin
                    fc  = FUNC_CODE_RESET;
                    len = DATA_LEN_RESET;
                end
                default: begin
                    fc  = 8'($urandom_range(0, 255));
                    len = 8'($urandom_range(0, 255));
                end
            endcase
            wait_replies_done(6);
            write_cfg_pair(fc, len);
            sent = 0;
            while (sent < PHASE_BYTES) begin
                build_random_frame(n);
                send_frame(n, $urandom_range(0, 99) >= 30);
                sent += n;
                if ($urandom_range(0, 49) == 0) begin
                    wait_replies_done(0);
                end
            end
        end

        wait_replies_done(10);
        if (err_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
`default_nettype wire
